// ----- rtl/pips_pkg.sv -----
// ----------------------------------------------------------------------------
// pips_pkg
// Shared constants and types for the pending interrupt priority set.
// ----------------------------------------------------------------------------
package pips_pkg;

   // Number of interrupt vectors tracked (2 to 64)
   localparam int VECTORS = 64;
   localparam int IDX_W   = (VECTORS > 1) ? $clog2(VECTORS) : 1;
   localparam int CNT_W   = $clog2(VECTORS + 1);

   // Fixed field widths of the channels
   localparam int OP_W    = 2;
   localparam int VEC_W   = 6;
   localparam int COUNT_W = 7;

   localparam logic [OP_W-1:0] OP_RAISE     = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd1;
   localparam logic [OP_W-1:0] OP_TAKE      = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 2'd3;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [VEC_W-1:0] vector;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               was_pending;
      logic [VEC_W-1:0]   taken_vector;
      logic [COUNT_W-1:0] pending_count;
   } rsp_type;

endpackage

// ----- rtl/pips_req_if.sv -----
// ----------------------------------------------------------------------------
// pips_req_if
// Request channel: operation and vector with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pips_req_if;
   import pips_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [VEC_W-1:0] vector;

   modport source (output valid, output operation, output vector, input ready);
   modport sink   (input valid, input operation, input vector, output ready);

endinterface

// ----- rtl/pips_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pips_rsp_if
// Response channel: status, pending query, taken vector and pending count.
// ----------------------------------------------------------------------------
interface pips_rsp_if;
   import pips_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic               was_pending;
   logic [VEC_W-1:0]   taken_vector;
   logic [COUNT_W-1:0] pending_count;

   modport source (output valid, output status, output was_pending,
                   output taken_vector, output pending_count, input ready);
   modport sink   (input valid, input status, input was_pending,
                   input taken_vector, input pending_count, output ready);

endinterface

// ----- rtl/pips_prio_enc.sv -----
// ----------------------------------------------------------------------------
// pips_prio_enc
// Lowest-set-bit priority encoder over the pending bitmap.
// ----------------------------------------------------------------------------
module pips_prio_enc (
   input  logic [pips_pkg::VECTORS-1:0] bits,
   output logic                         found,
   output logic [pips_pkg::IDX_W-1:0]   index
);
   import pips_pkg::*;

   logic [VECTORS-1:0] lowest;

   // Isolate lowest set bit, then OR together the index of the one-hot bit
   assign lowest = bits & (~bits + VECTORS'(1));
   assign found  = |bits;

   always_comb begin
      index = '0;
      for (int i = 0; i < VECTORS; i++) begin
         if (lowest[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

// ----- rtl/pips_core.sv -----
// ----------------------------------------------------------------------------
// pips_core
// Pending bitmap and count, with the raise/clear/take/clear-all update.
// ----------------------------------------------------------------------------
module pips_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  pips_pkg::req_type req,
   output pips_pkg::rsp_type rsp
);
   import pips_pkg::*;

   logic [VECTORS-1:0] pending_ff;
   logic [VECTORS-1:0] pending_in;
   logic [CNT_W-1:0]   total_ff;
   logic [CNT_W-1:0]   total_in;

   logic               vec_ok;
   logic [IDX_W-1:0]   vec_idx;
   logic [VECTORS-1:0] vec_bit;
   logic               was;
   logic               found;
   logic [IDX_W-1:0]   low_idx;
   logic [VECTORS-1:0] low_bit;

   pips_prio_enc u_prio_enc (
      .bits  (pending_ff),
      .found (found),
      .index (low_idx)
   );

   assign vec_ok  = ({1'b0, req.vector} < (VEC_W + 1)'(VECTORS));
   assign vec_idx = IDX_W'(req.vector);
   assign vec_bit = vec_ok ? (VECTORS'(1) << vec_idx) : '0;
   assign was     = |(pending_ff & vec_bit);
   assign low_bit = VECTORS'(1) << low_idx;

   always_comb begin
      pending_in        = pending_ff;
      total_in          = total_ff;
      rsp.status        = STATUS_DONE;
      rsp.was_pending   = was;
      rsp.taken_vector  = '0;
      unique case (req.operation)
         OP_RAISE: begin
            if (!vec_ok || was) begin
               rsp.status = STATUS_REFUSED;
            end else begin
               pending_in = pending_ff | vec_bit;
               total_in   = total_ff + CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            if (!was) begin
               rsp.status = STATUS_REFUSED;
            end else begin
               pending_in = pending_ff & ~vec_bit;
               total_in   = total_ff - CNT_W'(1);
            end
         end
         OP_TAKE: begin
            if (!found) begin
               rsp.status = STATUS_REFUSED;
            end else begin
               pending_in       = pending_ff & ~low_bit;
               total_in         = total_ff - CNT_W'(1);
               rsp.taken_vector = VEC_W'(low_idx);
            end
         end
         OP_CLEAR_ALL: begin
            pending_in = '0;
            total_in   = '0;
         end
         default: begin
            rsp.status = STATUS_REFUSED;
         end
      endcase
      rsp.pending_count = COUNT_W'(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         total_ff   <= '0;
      end else if (enable) begin
         pending_ff <= pending_in;
         total_ff   <= total_in;
      end
   end

endmodule

// ----- rtl/pending_interrupt_priority_set.sv -----
// An accepted request is processed once the response register is free or draining.
// Throughput: one operation per cycle unless rsp ready stalls the response register.
// A request register feeds the combinational update and pick, a response register holds
// the result, so one new request is taken while a finished response waits for rsp ready.
// Reset (synchronous, active high) empties the pending set and drops both stages.
// ----------------------------------------------------------------------------
// pending_interrupt_priority_set
// Pending interrupt vector set with lowest-vector-first take.
// ----------------------------------------------------------------------------
module pending_interrupt_priority_set (
   input logic       clock,
   input logic       reset,
   pips_req_if.sink  req_chan,
   pips_rsp_if.source rsp_chan
);
   import pips_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    req_take;

   // Request stage moves on when the response register is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   pips_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .req    (in_ff),
      .rsp    (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.operation <= req_chan.operation;
         in_ff.vector    <= req_chan.vector;
      end
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_ff.status;
   assign rsp_chan.was_pending   = out_ff.was_pending;
   assign rsp_chan.taken_vector  = out_ff.taken_vector;
   assign rsp_chan.pending_count = out_ff.pending_count;

endmodule

// ----- rtl/pips_checker.sv -----
// ----------------------------------------------------------------------------
// pips_checker
// Port-level checks on the pending interrupt priority set.
// ----------------------------------------------------------------------------
module pips_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_status,
   input logic [pips_pkg::VEC_W-1:0]   rsp_taken_vector,
   input logic [pips_pkg::COUNT_W-1:0] rsp_pending_count
);
   import pips_pkg::*;

   // A stalled response stays presented
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Count never exceeds the number of vectors
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pending_count <= COUNT_W'(VECTORS)))
      else $error("pending count out of range");

   // A nonzero taken vector only comes with a successful take
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_taken_vector != '0) |-> (rsp_status == STATUS_DONE))
      else $error("taken vector on refused operation");

   // With the response side free, a request is never back-pressured
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid |-> req_ready)
      else $error("request stalled with empty response stage");

endmodule

bind pending_interrupt_priority_set pips_checker u_pips_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_taken_vector  (rsp_chan.taken_vector),
   .rsp_pending_count (rsp_chan.pending_count)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives raise, clear, take and clear-all operations into the pending
// interrupt set and checks every response against the typed-in response of
// its table row or a bitmap predictor kept in step with each accepted
// request. A short table of corner cases comes first, followed by random
// fill, drain and mixed traffic under three idle profiles on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pips_pkg::*;

   localparam int PHASE_ITEMS = 450;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   // one directed row: request, whether the response is typed in, and that response
   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [VEC_W-1:0]   vector;
      logic               known;
      logic               status;
      logic               was_pending;
      logic [VEC_W-1:0]   taken_vector;
      logic [COUNT_W-1:0] pending_count;
   } corner_row_type;

   localparam int CORNER_ROWS = 21;
   localparam corner_row_type CORNER_TABLE [CORNER_ROWS] = '{
      '{OP_TAKE,      6'd0,  1'b1, STATUS_REFUSED, 1'b0, 6'd0,  7'd0},
      '{OP_CLEAR,     6'd63, 1'b1, STATUS_REFUSED, 1'b0, 6'd0,  7'd0},
      '{OP_CLEAR_ALL, 6'd0,  1'b1, STATUS_DONE,    1'b0, 6'd0,  7'd0},
      '{OP_RAISE,     6'd63, 1'b1, STATUS_DONE,    1'b0, 6'd0,  7'd1},
      '{OP_RAISE,     6'd63, 1'b1, STATUS_REFUSED, 1'b1, 6'd0,  7'd1},
      '{OP_RAISE,     6'd0,  1'b1, STATUS_DONE,    1'b0, 6'd0,  7'd2},
      '{OP_TAKE,      6'd63, 1'b1, STATUS_DONE,    1'b1, 6'd0,  7'd1},
      '{OP_TAKE,      6'd0,  1'b1, STATUS_DONE,    1'b0, 6'd63, 7'd0},
      '{OP_TAKE,      6'd63, 1'b1, STATUS_REFUSED, 1'b0, 6'd0,  7'd0},
      '{OP_RAISE,     6'd42, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_RAISE,     6'd21, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_RAISE,     6'd1,  1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_CLEAR,     6'd42, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_CLEAR,     6'd42, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_TAKE,      6'd21, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_RAISE,     6'd32, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_RAISE,     6'd31, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_CLEAR_ALL, 6'd31, 1'b1, STATUS_DONE,    1'b1, 6'd0,  7'd0},
      '{OP_RAISE,     6'd62, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_TAKE,      6'd62, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0},
      '{OP_CLEAR_ALL, 6'd63, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pips_req_if req_chan ();
   pips_rsp_if rsp_chan ();

   pending_interrupt_priority_set DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   logic [63:0]        pending_map = '0;
   logic [COUNT_W-1:0] pending_total = '0;

   rsp_type expected_rsp [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // applies one accepted request to the predicted bitmap and returns its response
   function automatic rsp_type apply_operation(input req_type item);
      rsp_type res;
      logic    in_range;
      int      lowest;
      in_range = int'(item.vector) < VECTORS;
      res.status = STATUS_DONE;
      res.was_pending = in_range && pending_map[item.vector];
      res.taken_vector = '0;
      case (item.operation)
         OP_RAISE: begin
            if (!in_range || res.was_pending) begin
               res.status = STATUS_REFUSED;
            end else begin
               pending_map[item.vector] = 1'b1;
               pending_total = pending_total + 1'b1;
            end
         end
         OP_CLEAR: begin
            if (!res.was_pending) begin
               res.status = STATUS_REFUSED;
            end else begin
               pending_map[item.vector] = 1'b0;
               pending_total = pending_total - 1'b1;
            end
         end
         OP_TAKE: begin
            if (pending_map == '0) begin
               res.status = STATUS_REFUSED;
            end else begin
               lowest = 0;
               while (!pending_map[lowest]) lowest++;
               res.taken_vector = lowest[VEC_W-1:0];
               pending_map[lowest] = 1'b0;
               pending_total = pending_total - 1'b1;
            end
         end
         default: begin
            pending_map = '0;
            pending_total = '0;
         end
      endcase
      res.pending_count = pending_total;
      return res;
   endfunction

   // vector whose pending bit matches want_set, random when none does
   function automatic logic [VEC_W-1:0] pick_vector(input logic want_set);
      int start;
      int idx;
      start = $urandom_range(VECTORS - 1);
      for (int k = 0; k < VECTORS; k++) begin
         idx = (start + k) % VECTORS;
         if (pending_map[idx] == want_set) return idx[VEC_W-1:0];
      end
      return VEC_W'($urandom);
   endfunction

   function automatic req_type make_item(input traffic_mode_type mode);
      req_type item;
      int      roll;
      roll = $urandom_range(99);
      item.operation = OP_W'($urandom);
      item.vector = VEC_W'($urandom);
      if (roll < 15) return item;   // noise: anything at all
      case (mode)
         MODE_FILL: begin
            item.operation = OP_RAISE;
            item.vector = pick_vector(1'b0);
         end
         MODE_DRAIN: begin
            if (roll < 60) begin
               item.operation = OP_TAKE;
            end else begin
               item.operation = OP_CLEAR;
               item.vector = pick_vector(1'b1);
            end
         end
         default: begin
            if (roll < 18) item.operation = OP_CLEAR_ALL;
            else if (roll < 50) item.operation = OP_RAISE;
            else if (roll < 75) item.operation = OP_CLEAR;
            else item.operation = OP_TAKE;
            if (item.operation != OP_CLEAR_ALL && roll[0]) begin
               item.vector = pick_vector(item.operation == OP_CLEAR);
            end
         end
      endcase
      return item;
   endfunction

   // one transfer on the request channel; called at a falling edge, returns at one
   task automatic send_request(input req_type item, input logic known, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.operation = item.operation;
      req_chan.vector = item.vector;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = apply_operation(item);
      expected_rsp.push_back(known ? want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic report_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %0d/%0d/%0d/%0d",
                     $time, rsp_chan.status, rsp_chan.was_pending,
                     rsp_chan.taken_vector, rsp_chan.pending_count);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            report_field("status", want.status, rsp_chan.status);
            report_field("was_pending", want.was_pending, rsp_chan.was_pending);
            report_field("taken_vector", want.taken_vector, rsp_chan.taken_vector);
            report_field("pending_count", want.pending_count, rsp_chan.pending_count);
         end
      end
   end

   initial begin : stimulus
      req_type          item;
      rsp_type          want;
      traffic_mode_type mode;
      int               burst_left;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_RAISE;
      req_chan.vector = '0;
      mode = MODE_FILL;
      burst_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 73;
      foreach (CORNER_TABLE[i]) begin
         item.operation = CORNER_TABLE[i].operation;
         item.vector = CORNER_TABLE[i].vector;
         want.status = CORNER_TABLE[i].status;
         want.was_pending = CORNER_TABLE[i].was_pending;
         want.taken_vector = CORNER_TABLE[i].taken_vector;
         want.pending_count = CORNER_TABLE[i].pending_count;
         send_request(item, CORNER_TABLE[i].known, want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         // sender holds off until the block has returned everything
         wait_drained();
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 34 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               mode = traffic_mode_type'($urandom_range(2));
               burst_left = $urandom_range(1, 80);
            end
            burst_left--;
            send_request(make_item(mode), 1'b0, want);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_400_000;
      $display("testbench failed");
      $finish;
   end

endmodule
